@@ design/vec3au_pkg.sv @@
// vec3au_pkg: shared types and constants of the 3d vector arithmetic unit
// used by vec3au_div, vector3_arith_unit and tb_vector3_arith_unit
// no dependencies

package vec3au_pkg;

   // default component width, signed Q8.8
   localparam int COMP_WIDTH_DEF = 16;

   // operation code width and codes
   localparam int FUNC_W = 3;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_DOT = 3'd2,
      FUNC_LEN = 3'd3,
      FUNC_COS = 3'd4
   } func_type;

   // cosine result, signed Q2.14
   localparam int COS_W    = 16;
   localparam int COS_FRAC = 14;
   localparam int COS_ONE  = 16384;
   localparam int QMAG_W   = 15;

   // quotient bits resolved by the divider (quotient stays below 2^17)
   localparam int QUO_BITS = 17;

endpackage

@@ design/vector3_arith_unit.sv @@
// vector3_arith_unit: 3d vector add, subtract, dot, length and cosine, top level
// depends on vec3au_pkg, vec3au_lane, vec3au_sqrt, vec3au_div
//
//  channel | dir | ports                     | word
//  req     | in  | req_tvalid/tready/tdata/tuser | a_x..b_z in tdata, func in tuser
//  rsp     | out | rsp_tvalid/tready/tdata   | r_x, r_y, r_z, dot, length, cosine, flags
//
// one word accepted per cycle unless an rsp word is held and not taken; the pipeline
// depth is set by the square root (one stage per root bit) and divider (17 stages)
// synchronous reset clears all valid bits; data registers are not reset
// a held rsp word stalls the whole pipeline; empty stages still fill behind it
// only once the output register is free

module vector3_arith_unit #(
   parameter int COMPONENT_WIDTH = vec3au_pkg::COMP_WIDTH_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z from bit 0 up, zero padded
   input  logic [((6*COMPONENT_WIDTH+7)/8)*8-1:0]  req_tdata,
   // func
   input  logic [vec3au_pkg::FUNC_W-1:0]           req_tuser,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // r_x, r_y, r_z, dot_value, length_value, cosine_value, overflow,
   // zero_vector from bit 0 up, zero padded
   output logic [((6*COMPONENT_WIDTH+19+7)/8)*8-1:0] rsp_tdata
);

   import vec3au_pkg::*;

   localparam int CW       = COMPONENT_WIDTH;
   localparam int PW       = 2 * CW;
   localparam int DW       = 2 * CW + 1;
   localparam int OUT_BITS = 6 * CW + 19;
   localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;
   localparam int CAR_N    = CW + 2 + QUO_BITS;
   localparam int TAP_DIV  = CW + 1;
   localparam int LEN_N    = QUO_BITS + 1;

   logic en;

   // input register
   logic                 v1_ff;
   func_type             func1_ff;
   logic signed [CW-1:0] a1_ff [3];
   logic signed [CW-1:0] b1_ff [3];

   // lane outputs
   logic                 v2_ff;
   func_type             func2_ff;
   logic signed [CW-1:0] sum2 [3];
   logic                 ovf2 [3];
   logic signed [PW-1:0] pab2 [3];
   logic signed [PW-1:0] paa2 [3];
   logic signed [PW-1:0] pbb2 [3];

   // merge results
   logic signed [DW-1:0] dot_c;
   logic [PW-1:0]        sa_c;
   logic [PW-1:0]        sb_c;

   // carried fields along the root and divide pipeline
   logic                 cv_ff    [CAR_N];
   func_type             cfunc_ff [CAR_N];
   logic signed [CW-1:0] crx_ff   [CAR_N];
   logic signed [CW-1:0] cry_ff   [CAR_N];
   logic signed [CW-1:0] crz_ff   [CAR_N];
   logic                 covf_ff  [CAR_N];
   logic signed [DW-1:0] cdot_ff  [CAR_N];
   logic                 czero_ff [CAR_N];

   logic [PW-1:0]        sa_ff;
   logic [PW-1:0]        sb_ff;
   logic [CW-1:0]        root_a;
   logic [CW-1:0]        root_b;
   logic [PW-1:0]        prod_ff;
   logic [CW-1:0]        len_ff [LEN_N];
   logic signed [DW-1:0] div_dot;
   logic [PW-1:0]        mag;
   logic [QMAG_W-1:0]    quo;

   // output register
   logic                 rsp_valid_ff;
   logic [OUT_W-1:0]     rsp_data_ff;
   logic [OUT_W-1:0]     rsp_data_in;

   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // input register, plus the lane stage valid and func
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         func1_ff <= func_type'(req_tuser);
         func2_ff <= func1_ff;
         for (int i = 0; i < 3; i++) begin
            a1_ff[i] <= req_tdata[i*CW +: CW];
            b1_ff[i] <= req_tdata[(3+i)*CW +: CW];
         end
      end
   end

   // one lane per component
   genvar g;
   generate
      for (g = 0; g < 3; g++) begin : g_lane
         vec3au_lane #(.CW(CW)) u_lane (
            .clock  (clock),
            .en     (en),
            .sub    (func1_ff == FUNC_SUB),
            .a      (a1_ff[g]),
            .b      (b1_ff[g]),
            .sum_ff (sum2[g]),
            .ovf_ff (ovf2[g]),
            .pab_ff (pab2[g]),
            .paa_ff (paa2[g]),
            .pbb_ff (pbb2[g])
         );
      end
   endgenerate

   // merge the lanes
   assign dot_c = DW'(pab2[0]) + DW'(pab2[1]) + DW'(pab2[2]);
   assign sa_c  = $unsigned(paa2[0]) + $unsigned(paa2[1]) + $unsigned(paa2[2]);
   assign sb_c  = $unsigned(pbb2[0]) + $unsigned(pbb2[1]) + $unsigned(pbb2[2]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CAR_N; k++) begin
            cv_ff[k] <= 1'b0;
         end
      end else if (en) begin
         cv_ff[0] <= v2_ff;
         for (int k = 1; k < CAR_N; k++) begin
            cv_ff[k] <= cv_ff[k-1];
         end
      end
   end

   // carried fields shift along with the valid bits
   always_ff @(posedge clock) begin
      if (en) begin
         cfunc_ff[0] <= func2_ff;
         crx_ff[0]   <= sum2[0];
         cry_ff[0]   <= sum2[1];
         crz_ff[0]   <= sum2[2];
         covf_ff[0]  <= ovf2[0] | ovf2[1] | ovf2[2];
         cdot_ff[0]  <= dot_c;
         czero_ff[0] <= (sa_c == '0) || (sb_c == '0);
         sa_ff       <= sa_c;
         sb_ff       <= sb_c;
         for (int k = 1; k < CAR_N; k++) begin
            cfunc_ff[k] <= cfunc_ff[k-1];
            crx_ff[k]   <= crx_ff[k-1];
            cry_ff[k]   <= cry_ff[k-1];
            crz_ff[k]   <= crz_ff[k-1];
            covf_ff[k]  <= covf_ff[k-1];
            cdot_ff[k]  <= cdot_ff[k-1];
            czero_ff[k] <= czero_ff[k-1];
         end
      end
   end

   // norms of both vectors
   vec3au_sqrt #(.CW(CW)) u_sqrt_a (
      .clock (clock),
      .en    (en),
      .n     (sa_ff),
      .root  (root_a)
   );

   vec3au_sqrt #(.CW(CW)) u_sqrt_b (
      .clock (clock),
      .en    (en),
      .n     (sb_ff),
      .root  (root_b)
   );

   // norm product and length delay line
   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff   <= root_a * root_b;
         len_ff[0] <= root_a;
         for (int k = 1; k < LEN_N; k++) begin
            len_ff[k] <= len_ff[k-1];
         end
      end
   end

   // magnitude of the dot product for the divider
   assign div_dot = cdot_ff[TAP_DIV];
   assign mag     = div_dot[DW-1] ? PW'(-div_dot) : PW'(div_dot);

   vec3au_div #(.CW(CW)) u_div (
      .clock (clock),
      .en    (en),
      .mag   (mag),
      .dvs   (prod_ff),
      .quo   (quo)
   );

   // result word assembly
   always_comb begin
      logic signed [COS_W-1:0] cos_v;
      rsp_data_in = '0;
      cos_v       = cdot_ff[CAR_N-1][DW-1] ? -COS_W'(quo) : COS_W'(quo);
      case (cfunc_ff[CAR_N-1])
         FUNC_ADD, FUNC_SUB: begin
            rsp_data_in[0 +: CW]      = crx_ff[CAR_N-1];
            rsp_data_in[CW +: CW]     = cry_ff[CAR_N-1];
            rsp_data_in[2*CW +: CW]   = crz_ff[CAR_N-1];
            rsp_data_in[6*CW + 17]    = covf_ff[CAR_N-1];
         end
         FUNC_DOT: begin
            rsp_data_in[3*CW +: DW]   = cdot_ff[CAR_N-1];
         end
         FUNC_LEN: begin
            rsp_data_in[5*CW+1 +: CW] = len_ff[LEN_N-1];
         end
         FUNC_COS: begin
            if (czero_ff[CAR_N-1]) begin
               rsp_data_in[6*CW + 18] = 1'b1;
            end else begin
               rsp_data_in[6*CW+1 +: COS_W] = cos_v;
            end
         end
         default: begin
            rsp_data_in = '0;
         end
      endcase
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= cv_ff[CAR_N-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_zero_clears_cos : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6*CW + 18] |-> rsp_tdata[6*CW+1 +: COS_W] == '0)
      else $error("cosine not zero for a zero-length vector");

   a_ovf_only_vector : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[6*CW + 17] |->
         rsp_tdata[3*CW +: DW] == '0 && rsp_tdata[6*CW + 18] == 1'b0)
      else $error("overflow flag on a scalar result");

   a_flags_exclusive : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[6*CW + 17] && rsp_tdata[6*CW + 18]))
      else $error("overflow and zero-vector flags together");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

@@ design/vec3au_lane.sv @@
// vec3au_lane: one component lane, saturating add or subtract and three products
// depends on nothing but its parameter

module vec3au_lane #(
   parameter int CW = 16
) (
   input  logic                   clock,
   input  logic                   en,
   input  logic                   sub,
   input  logic signed [CW-1:0]   a,
   input  logic signed [CW-1:0]   b,
   output logic signed [CW-1:0]   sum_ff,
   output logic                   ovf_ff,
   output logic signed [2*CW-1:0] pab_ff,
   output logic signed [2*CW-1:0] paa_ff,
   output logic signed [2*CW-1:0] pbb_ff
);

   logic signed [CW:0]   wide_in;
   logic signed [CW-1:0] sum_in;
   logic                 ovf_in;

   // add or subtract with one guard bit, then clamp
   always_comb begin
      if (sub) begin
         wide_in = (CW+1)'(a) - (CW+1)'(b);
      end else begin
         wide_in = (CW+1)'(a) + (CW+1)'(b);
      end
      ovf_in = wide_in[CW] ^ wide_in[CW-1];
      if (ovf_in) begin
         sum_in = wide_in[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
      end else begin
         sum_in = wide_in[CW-1:0];
      end
   end

   // lane register
   always_ff @(posedge clock) begin
      if (en) begin
         sum_ff <= sum_in;
         ovf_ff <= ovf_in;
         pab_ff <= a * b;
         paa_ff <= a * a;
         pbb_ff <= b * b;
      end
   end

endmodule

@@ design/vec3au_sqrt.sv @@
// vec3au_sqrt: pipelined integer square root, one result bit per stage
// depends on nothing but its parameter

module vec3au_sqrt #(
   parameter int CW = 16
) (
   input  logic            clock,
   input  logic            en,
   input  logic [2*CW-1:0] n,
   output logic [CW-1:0]   root
);

   localparam int PW = 2 * CW;

   logic [PW-1:0] rem_ff [CW];
   logic [PW-1:0] res_ff [CW];

   genvar j;
   generate
      for (j = 0; j < CW; j++) begin : g_stage
         logic [PW-1:0] rem_prev;
         logic [PW-1:0] res_prev;
         logic [PW-1:0] bitv;
         logic [PW-1:0] trial;
         logic [PW-1:0] rem_in;
         logic [PW-1:0] res_in;

         // one digit of the root per stage
         always_comb begin
            if (j == 0) begin
               rem_prev = n;
               res_prev = '0;
            end else begin
               rem_prev = rem_ff[(j == 0) ? 0 : j-1];
               res_prev = res_ff[(j == 0) ? 0 : j-1];
            end
            bitv  = PW'(1) << (PW - 2 - 2*j);
            trial = res_prev + bitv;
            if (rem_prev >= trial) begin
               rem_in = rem_prev - trial;
               res_in = (res_prev >> 1) + bitv;
            end else begin
               rem_in = rem_prev;
               res_in = res_prev >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               res_ff[j] <= res_in;
            end
         end
      end
   endgenerate

   assign root = res_ff[CW-1][CW-1:0];

endmodule

@@ design/vec3au_div.sv @@
// vec3au_div: pipelined restoring divider for the cosine, one quotient bit per stage
// depends on vec3au_pkg

module vec3au_div #(
   parameter int CW = 16
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [2*CW-1:0]                mag,
   input  logic [2*CW-1:0]                dvs,
   output logic [vec3au_pkg::QMAG_W-1:0]  quo
);

   import vec3au_pkg::*;

   localparam int PW = 2 * CW;
   localparam int RW = PW + QUO_BITS;

   logic [RW-1:0]       rem_ff [QUO_BITS];
   logic [PW-1:0]       dvs_ff [QUO_BITS];
   logic [QUO_BITS-1:0] q_ff   [QUO_BITS];

   genvar j;
   generate
      for (j = 0; j < QUO_BITS; j++) begin : g_stage
         logic [RW-1:0]       rem_prev;
         logic [PW-1:0]       dvs_prev;
         logic [QUO_BITS-1:0] q_prev;
         logic [RW-1:0]       shifted;
         logic [RW-1:0]       rem_in;
         logic [QUO_BITS-1:0] q_in;

         // quotient bits from the top down, divisor shifted left by QUO_BITS - 1 - j in stage j
         always_comb begin
            if (j == 0) begin
               rem_prev = RW'(mag) << COS_FRAC;
               dvs_prev = dvs;
               q_prev   = '0;
            end else begin
               rem_prev = rem_ff[(j == 0) ? 0 : j-1];
               dvs_prev = dvs_ff[(j == 0) ? 0 : j-1];
               q_prev   = q_ff[(j == 0) ? 0 : j-1];
            end
            shifted = RW'(dvs_prev) << (QUO_BITS - 1 - j);
            if (rem_prev >= shifted) begin
               rem_in = rem_prev - shifted;
               q_in   = q_prev | (QUO_BITS'(1) << (QUO_BITS - 1 - j));
            end else begin
               rem_in = rem_prev;
               q_in   = q_prev;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[j] <= rem_in;
               dvs_ff[j] <= dvs_prev;
               q_ff[j]   <= q_in;
            end
         end
      end
   endgenerate

   // clamp to one in Q2.14
   assign quo = (q_ff[QUO_BITS-1] > QUO_BITS'(COS_ONE)) ? QMAG_W'(COS_ONE)
                                                        : q_ff[QUO_BITS-1][QMAG_W-1:0];

endmodule

@@ test/tb_vector3_arith_unit.sv @@
// tb_vector3_arith_unit: stream testbench for the 3d vector arithmetic unit
// checks add, subtract, dot, length and cosine words against an inline predictor
// depends on vec3au_pkg and vector3_arith_unit

module tb_vector3_arith_unit;
   timeunit 1ns;
   timeprecision 1ps;
   import vec3au_pkg::*;

   localparam int CW     = 16;
   localparam int DW     = ((6*CW+7)/8)*8;
   localparam int RW     = ((6*CW+19+7)/8)*8;
   localparam int LAT    = CW + 22;
   localparam int SMAX   = (1 << (CW-1)) - 1;
   localparam int SMIN   = -(1 << (CW-1));

   typedef struct {
      logic [2:0]    func;
      logic [CW-1:0] a [3];
      logic [CW-1:0] b [3];
   } vec_pair_type;

   typedef struct {
      logic [CW-1:0]   r [3];
      logic [2*CW:0]   dot;
      logic [CW-1:0]   len;
      logic [15:0]     cosv;
      logic            ovf;
      logic            zvec;
   } vec_result_type;

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [DW-1:0] req_tdata = '0;
   logic [2:0]    req_tuser = '0;
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [RW-1:0] rsp_tdata;

   vec_pair_type   pending_words [$];
   vec_result_type expected_words [$];
   int             error_count = 0;
   bit             hold_rsp = 1'b0;
   bit             hold_req = 1'b0;
   int             burst_left = 0;
   int             gap_left = 0;
   int             stall_left = 0;

   vector3_arith_unit #(.COMPONENT_WIDTH(CW)) u_dut (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // truncated integer square root
   function automatic longint unsigned isqrt(longint unsigned n);
      longint unsigned root, bitv;
      root = 0;
      bitv = 64'd1 << 62;
      while (bitv > n) bitv >>= 2;
      while (bitv != 0) begin
         if (n >= root + bitv) begin
            n -= root + bitv;
            root = (root >> 1) + bitv;
         end else begin
            root >>= 1;
         end
         bitv >>= 2;
      end
      return root;
   endfunction

   function automatic vec_result_type vector_result(vec_pair_type w);
      vec_result_type  res;
      longint          av [3], bv [3];
      longint          s, dotp;
      longint unsigned sa, sb, prod, mag, q;
      bit              ovf;
      res.r = '{default: '0};
      res.dot = '0;
      res.len = '0;
      res.cosv = '0;
      res.ovf = 1'b0;
      res.zvec = 1'b0;
      ovf = 1'b0;
      for (int i = 0; i < 3; i++) begin
         av[i] = longint'($signed(w.a[i]));
         bv[i] = longint'($signed(w.b[i]));
      end
      dotp = av[0]*bv[0] + av[1]*bv[1] + av[2]*bv[2];
      sa = av[0]*av[0] + av[1]*av[1] + av[2]*av[2];
      sb = bv[0]*bv[0] + bv[1]*bv[1] + bv[2]*bv[2];
      case (w.func)
         FUNC_ADD, FUNC_SUB: begin
            for (int i = 0; i < 3; i++) begin
               s = (w.func == FUNC_ADD) ? av[i] + bv[i] : av[i] - bv[i];
               if (s > SMAX) begin
                  s = SMAX;
                  ovf = 1'b1;
               end else if (s < SMIN) begin
                  s = SMIN;
                  ovf = 1'b1;
               end
               res.r[i] = s[CW-1:0];
            end
            res.ovf = ovf;
         end
         FUNC_DOT: res.dot = dotp[2*CW:0];
         FUNC_LEN: res.len = CW'(isqrt(sa));
         FUNC_COS: begin
            if (sa == 0 || sb == 0) begin
               res.zvec = 1'b1;
            end else begin
               prod = isqrt(sa) * isqrt(sb);
               mag = (dotp < 0) ? -dotp : dotp;
               q = (mag << COS_FRAC) / prod;
               if (q > COS_ONE) q = COS_ONE;
               s = (dotp < 0) ? -longint'(q) : longint'(q);
               res.cosv = s[15:0];
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic report_mismatch(string field, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0h want %0h at %0t", field, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [CW-1:0] rand_comp();
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: return SMAX[CW-1:0];
         1: return SMIN[CW-1:0];
         2: return '0;
         3: return CW'($urandom_range(0, 15)) - CW'(8);
         default: return CW'($urandom);
      endcase
   endfunction

   task automatic push_word(logic [2:0] f, int a0, int a1, int a2, int b0, int b1, int b2);
      vec_pair_type w;
      w.func = f;
      w.a = '{CW'(a0), CW'(a1), CW'(a2)};
      w.b = '{CW'(b0), CW'(b1), CW'(b2)};
      pending_words.push_back(w);
   endtask

   // driver: bursts and gaps, words popped from the pending queue
   always @(posedge clock) begin
      vec_pair_type w;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            if (!hold_req && gap_left == 0 && pending_words.size() > 0) begin
               w = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= w.func;
               req_tdata <= DW'({w.b[2], w.b[1], w.b[0], w.a[2], w.a[1], w.a[0]});
               expected_words.push_back(vector_result(w));
               if (burst_left > 0) begin
                  burst_left <= burst_left - 1;
               end else begin
                  burst_left <= $urandom_range(0, 30);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver stall pattern plus forced long hold
   always @(posedge clock) begin
      if (!reset) begin
         if (hold_rsp) begin
            rsp_tready <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
            if ($urandom_range(0, 7) == 0) stall_left <= $urandom_range(1, 5);
         end
      end
   end

   // monitor: compare each accepted rsp word with the oldest prediction
   always @(posedge clock) begin
      vec_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected word", 64'(rsp_tdata), 64'(0));
         end else begin
            want = expected_words.pop_front();
            for (int i = 0; i < 3; i++)
               if (rsp_tdata[i*CW +: CW] !== want.r[i])
                  report_mismatch($sformatf("r[%0d]", i), 64'(rsp_tdata[i*CW +: CW]),
                                  64'(want.r[i]));
            if (rsp_tdata[3*CW +: 2*CW+1] !== want.dot)
               report_mismatch("dot_value", 64'(rsp_tdata[3*CW +: 2*CW+1]), 64'(want.dot));
            if (rsp_tdata[5*CW+1 +: CW] !== want.len)
               report_mismatch("length_value", 64'(rsp_tdata[5*CW+1 +: CW]), 64'(want.len));
            if (rsp_tdata[6*CW+1 +: 16] !== want.cosv)
               report_mismatch("cosine_value", 64'(rsp_tdata[6*CW+1 +: 16]), 64'(want.cosv));
            if (rsp_tdata[6*CW+17] !== want.ovf)
               report_mismatch("overflow", 64'(rsp_tdata[6*CW+17]), 64'(want.ovf));
            if (rsp_tdata[6*CW+18] !== want.zvec)
               report_mismatch("zero_vector", 64'(rsp_tdata[6*CW+18]), 64'(want.zvec));
         end
      end
   end

   // stimulus and end of run
   initial begin
      logic [2:0] f;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed words: extremes, each operation, saturation, zero length, clamp, undefined codes
      push_word(FUNC_ADD, SMAX, SMIN, 1, 1, -1, 0);
      push_word(FUNC_ADD, SMIN, SMAX, SMAX, SMIN, 1, SMAX);
      push_word(FUNC_SUB, SMIN, SMAX, 0, 1, -1, SMIN);
      push_word(FUNC_SUB, 5, -5, 7, 2, 3, 4);
      push_word(FUNC_DOT, SMIN, SMIN, SMIN, SMIN, SMIN, SMIN);
      push_word(FUNC_DOT, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
      push_word(FUNC_DOT, 256, -512, 3, 7, 9, -11);
      push_word(FUNC_LEN, SMIN, SMIN, SMIN, 0, 0, 0);
      push_word(FUNC_LEN, SMAX, 0, 0, 1, 1, 1);
      push_word(FUNC_LEN, 0, 0, 0, SMIN, SMAX, 0);
      push_word(FUNC_COS, 0, 0, 0, 256, 0, 0);
      push_word(FUNC_COS, 256, 0, 0, 0, 0, 0);
      push_word(FUNC_COS, 1, 1, 1, 1, 1, 1);
      push_word(FUNC_COS, 1, 1, 0, -1, -1, 0);
      push_word(FUNC_COS, SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
      push_word(FUNC_COS, 256, 0, 0, 0, 256, 0);
      push_word(3'd5, SMAX, SMAX, SMAX, SMAX, SMAX, SMAX);
      push_word(3'd6, 1, 2, 3, 4, 5, 6);
      push_word(3'd7, -1, -1, -1, -1, -1, -1);

      // random words
      for (int n = 0; n < 950; n++) begin
         f = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
         push_word(f, int'(rand_comp()), int'(rand_comp()), int'(rand_comp()),
                   int'(rand_comp()), int'(rand_comp()), int'(rand_comp()));
         if (n == 300) begin
            // long receiver hold while the sender keeps offering words
            wait (pending_words.size() < 200);
            hold_rsp = 1'b1;
            for (int c = 0; c < 4*LAT; c++) @(posedge clock);
            hold_rsp = 1'b0;
         end
         if (n == 600) begin
            // sender pause until everything has drained
            wait (pending_words.size() == 0);
            hold_req = 1'b1;
            @(posedge clock);
            wait (expected_words.size() == 0 && !req_tvalid);
            hold_req = 1'b0;
         end
      end
      wait (pending_words.size() == 0);
      wait (expected_words.size() == 0);
      repeat (2*LAT) @(posedge clock);
      if (error_count == 0 && expected_words.size() == 0)
         $display("PASS vector3_arith_unit");
      else
         $display("FAIL vector3_arith_unit");
      $finish;
   end

   // watchdog
   initial begin
      #2ms;
      $display("FAIL vector3_arith_unit");
      $finish;
   end

endmodule
